// ----- rtl/core/sspc_pkg.sv -----
// ----------------------------------------------------------------------------
// sspc_pkg: shared types and constants for the sensor sample pack and classify
// Holds the action and event codes, sensor range limits, the register layout
// and the structs that pass between the datapath and the top level.
// ----------------------------------------------------------------------------
package sspc_pkg;

	// Field widths of the streamed item and result.
	localparam int unsigned PRESS_W   = 21;
	localparam int unsigned TEMP_W    = 16;
	localparam int unsigned BATT_W    = 12;
	localparam int unsigned ACTION_W  = 2;
	localparam int unsigned WORD_W    = 32;
	localparam int unsigned EVENT_W   = 3;
	localparam int unsigned THRESH_W  = 19;
	localparam int unsigned CFG_IDX_W = 2;

	// Sample actions carried in the input tuser.
	typedef enum logic [ACTION_W-1:0] {
		ACT_SURFACE    = 2'd0,
		ACT_UNDERWATER = 2'd1,
		ACT_LIMP       = 2'd2
	} action_t;

	// Event codes reported with each result.
	typedef enum logic [EVENT_W-1:0] {
		EV_NONE     = 3'd0,
		EV_SUBMERGE = 3'd1,
		EV_SURFACE  = 3'd2,
		EV_BATT_LOW = 3'd3,
		EV_CHARGED  = 3'd4
	} event_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SUBMERGE_THRESH = 2'd0,
		REG_SURFACE_THRESH  = 2'd1,
		REG_BATT_LOW        = 2'd2,
		REG_BATT_CHARGED    = 2'd3
	} reg_idx_t;

	// Register reset values.
	localparam logic [THRESH_W-1:0] SUBMERGE_RST = 19'd17023;
	localparam logic [THRESH_W-1:0] SURFACE_RST  = 19'd16617;
	localparam logic [BATT_W-1:0]   BATT_LOW_RST = 12'd2300;
	localparam logic [BATT_W-1:0]   BATT_CHG_RST = 12'd2600;

	// Sensor ranges in fixed point.
	localparam logic [THRESH_W-1:0] PRESS_MAX_Q4    = 19'd524272; // 32767 mbar
	localparam logic [16:0]         TEMP_OFFSET_Q8  = 17'd1280;   // +5 degrees
	localparam logic [19:0]         TEMP_SCALED_MAX = 20'd1048320; // 35.95 degrees
	localparam logic [BATT_W-1:0]   BATT_MIN_MV     = 12'd1500;
	localparam logic [BATT_W-1:0]   BATT_MAX_MV     = 12'd3050;

	// Rounding offsets and the reciprocal of 50 in 16 fractional bits.
	localparam logic [THRESH_W-1:0] PRESS_HALF   = 19'd8;
	localparam logic [19:0]         TEMP_HALF    = 20'd128;
	localparam logic [10:0]         BATT_HALF    = 11'd25;
	localparam logic [10:0]         RECIP_50_Q16 = 11'd1311;

	// Threshold registers as seen by the datapath.
	typedef struct packed {
		logic [THRESH_W-1:0] submerge_threshold;
		logic [THRESH_W-1:0] surface_threshold;
		logic [BATT_W-1:0]   battery_low_mv;
		logic [BATT_W-1:0]   battery_charged_mv;
	} cfg_t;

	// One result beat.
	typedef struct packed {
		logic [WORD_W-1:0] packed_word;
		logic              sample_ready;
		event_t            event_code;
	} result_t;

endpackage

// ----- rtl/core/sspc_calc.sv -----
// ----------------------------------------------------------------------------
// sspc_calc: clamp, pack and classify one reading set
// Clamps the readings to their sensor ranges, packs them with rounding to
// nearest into one 32-bit word and picks the event code for the action.
// ----------------------------------------------------------------------------
module sspc_calc
	import sspc_pkg::*;
(
	input  logic [ACTION_W-1:0]      action,
	input  logic signed [PRESS_W-1:0] pressure_q4,
	input  logic signed [TEMP_W-1:0] temperature_q8,
	input  logic [BATT_W-1:0]        battery_mv,
	input  cfg_t                     cfg,
	output result_t                  result
);

	logic [THRESH_W-1:0] press_clamp;
	logic [THRESH_W-1:0] press_round;
	logic signed [16:0]  temp_shift;
	logic signed [23:0]  temp_ext;
	logic signed [23:0]  temp_scaled;
	logic [19:0]         temp_clamp;
	logic [19:0]         temp_round;
	logic [BATT_W-1:0]   batt_clamp;
	logic [10:0]         batt_ofs;
	logic [21:0]         batt_prod;
	logic [WORD_W-1:0]   word;

	// Pressure: negative readings go to zero, the top of the range saturates.
	always_comb begin
		if (pressure_q4[PRESS_W-1]) begin
			press_clamp = '0;
		end else if (pressure_q4[PRESS_W-2:0] > {1'b0, PRESS_MAX_Q4}) begin
			press_clamp = PRESS_MAX_Q4;
		end else begin
			press_clamp = pressure_q4[THRESH_W-1:0];
		end
		press_round = press_clamp + PRESS_HALF;
	end

	// Temperature: (t + 5 C) * 100 by shifts and adds, then clamp.
	always_comb begin
		temp_shift  = {temperature_q8[TEMP_W-1], temperature_q8} + $signed(TEMP_OFFSET_Q8);
		temp_ext    = {{7{temp_shift[16]}}, temp_shift};
		temp_scaled = (temp_ext <<< 6) + (temp_ext <<< 5) + (temp_ext <<< 2);
		if (temp_scaled[23]) begin
			temp_clamp = '0;
		end else if (temp_scaled[22:0] > {3'b0, TEMP_SCALED_MAX}) begin
			temp_clamp = TEMP_SCALED_MAX;
		end else begin
			temp_clamp = temp_scaled[19:0];
		end
		temp_round = temp_clamp + TEMP_HALF;
	end

	// Battery: clamp, then divide the rounded offset by 50 through a reciprocal.
	always_comb begin
		if (battery_mv < BATT_MIN_MV) begin
			batt_clamp = BATT_MIN_MV;
		end else if (battery_mv > BATT_MAX_MV) begin
			batt_clamp = BATT_MAX_MV;
		end else begin
			batt_clamp = battery_mv;
		end
		batt_ofs  = 11'(batt_clamp - BATT_MIN_MV) + BATT_HALF;
		batt_prod = 22'(batt_ofs) * 22'(RECIP_50_Q16);
	end

	assign word = {press_round[18:4], temp_round[19:8], batt_prod[20:16]};

	// Event selection; a low battery overrides the depth events.
	always_comb begin
		result.packed_word  = '0;
		result.sample_ready = 1'b0;
		result.event_code   = EV_NONE;
		case (action)
			ACT_SURFACE: begin
				result.packed_word  = word;
				result.sample_ready = 1'b1;
				if (press_clamp > cfg.submerge_threshold) begin
					result.event_code = EV_SUBMERGE;
				end
				if (batt_clamp < cfg.battery_low_mv) begin
					result.event_code = EV_BATT_LOW;
				end
			end
			ACT_UNDERWATER: begin
				result.packed_word  = word;
				result.sample_ready = 1'b1;
				if (press_clamp < cfg.surface_threshold) begin
					result.event_code = EV_SURFACE;
				end
				if (batt_clamp < cfg.battery_low_mv) begin
					result.event_code = EV_BATT_LOW;
				end
			end
			ACT_LIMP: begin
				if (battery_mv > cfg.battery_charged_mv) begin
					result.event_code = EV_CHARGED;
				end
			end
			default: begin
				result.event_code = EV_NONE;
			end
		endcase
	end

endmodule

// ----- rtl/core/sensor_sample_pack_and_classify.sv -----
// ----------------------------------------------------------------------------
// sensor_sample_pack_and_classify: sensor sample packer and event classifier
// An accepted input beat is held in the input register and then in the result register.
// Throughput: one beat per cycle while m_tready does not stall it, set by the input and result registers.
// A stalled result register still lets a new beat enter an empty input register.
// Reset clears both valid flags and loads the threshold registers with defaults.
// ----------------------------------------------------------------------------
module sensor_sample_pack_and_classify
	import sspc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// Input stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [55:0]          s_tdata,   // pressure_q4[20:0], temperature_q8[36:21],
	                                        // battery_mv[48:37], zero [55:49]
	input  logic [ACTION_W-1:0]  s_tuser,   // action[1:0]
	// Result stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [WORD_W-1:0]    m_tdata,   // packed_word[31:0]
	output logic [3:0]           m_tuser,   // sample_ready[0], event_code[3:1]
	// Configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [THRESH_W-1:0]  cfg_data
);

	logic                       valid_s1;
	logic [ACTION_W-1:0]        action_s1;
	logic signed [PRESS_W-1:0]  pressure_s1;
	logic signed [TEMP_W-1:0]   temperature_s1;
	logic [BATT_W-1:0]          battery_s1;
	logic                       valid_s2;
	result_t                    result_s2;
	result_t                    result_calc;
	cfg_t                       cfg_q;
	logic                       adv_s2;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.submerge_threshold <= SUBMERGE_RST;
			cfg_q.surface_threshold  <= SURFACE_RST;
			cfg_q.battery_low_mv     <= BATT_LOW_RST;
			cfg_q.battery_charged_mv <= BATT_CHG_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SUBMERGE_THRESH: cfg_q.submerge_threshold <= cfg_data;
				REG_SURFACE_THRESH:  cfg_q.surface_threshold  <= cfg_data;
				REG_BATT_LOW:        cfg_q.battery_low_mv     <= cfg_data[BATT_W-1:0];
				REG_BATT_CHARGED:    cfg_q.battery_charged_mv <= cfg_data[BATT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Handshake: the result register moves when empty or drained.
	assign adv_s2   = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv_s2;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			action_s1      <= s_tuser;
			pressure_s1    <= s_tdata[20:0];
			temperature_s1 <= s_tdata[36:21];
			battery_s1     <= s_tdata[48:37];
		end
	end

	sspc_calc u_calc (
		.action         (action_s1),
		.pressure_q4    (pressure_s1),
		.temperature_q8 (temperature_s1),
		.battery_mv     (battery_s1),
		.cfg            (cfg_q),
		.result         (result_calc)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			result_s2 <= result_calc;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = result_s2.packed_word;
	assign m_tuser  = {result_s2.event_code, result_s2.sample_ready};

`ifndef ASSERT_OFF
	// A result that is not a sample carries an all-zero word.
	a_nosample_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0)
		else $error("non-sample result with a non-zero packed word");

	// Depth and battery-low events only come with a sample.
	a_sample_events: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (result_s2.event_code == EV_SUBMERGE ||
		result_s2.event_code == EV_SURFACE || result_s2.event_code == EV_BATT_LOW)
		|-> result_s2.sample_ready)
		else $error("sample event without a sample");

	// The charged event only comes from the limp check.
	a_charged_limp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && result_s2.event_code == EV_CHARGED |-> !result_s2.sample_ready)
		else $error("charged event on a sample result");

	// The input side is never held off while the result side can move.
	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 |-> s_tready)
		else $error("input stalled while the result register can advance");

	// An accepted beat reaches the result register in the next cycle when free.
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s2 |=> valid_s2)
		else $error("beat lost between the input and result registers");
`endif

endmodule
